// File: design/sopt_pkg.sv
package sopt_pkg;

    // index width of the table, only the low bits of the request index count
    localparam int INDEX_WIDTH = 32;
    localparam int IDX_W       = (INDEX_WIDTH < 32) ? INDEX_WIDTH : 32;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int DIV_W     = 32;
    localparam int DIVISOR_W = 16;
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        REG_OFFSETS_PER_SEG = 2'd0,
        REG_SEGS_IN_BUCKET  = 2'd1,
        REG_SEG_WIDTH_BITS  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SEG,
        ST_DIV_BKT,
        ST_MUL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quot;
        logic [DIVISOR_W-1:0] rem;
    } div_rsp_t;

endpackage

// File: design/segmented_offset_position_tracker_unit.sv
// a request whose index is one past the previous one takes the counter step and goes
// straight to the output load; any other request takes two divides on the shared
// radix-2 divider, one multiply step and the output load
// a new request is taken only after the previous result is loaded into the output
// slot, and that load waits while an earlier result is stalled on m_ready
// reset: synchronous active-low aresetn; registers return to 1, no prior access,
// no result pending, no request taken while reset is low
module segmented_offset_position_tracker_unit
    import sopt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_entry_index,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_bucket_number,
    output logic [15:0]        m_segment_in_bucket,
    output logic [7:0]         m_position_in_segment,
    output logic [31:0]        m_segment_bit_offset,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // configuration registers
    logic [7:0]  offs_per_seg_reg;
    logic [15:0] segs_in_bucket_reg;
    logic [15:0] seg_width_reg;

    // tracker state
    state_t           state_reg, state_next;
    logic             last_valid_reg;
    logic [IDX_W-1:0] last_index_reg;
    logic [31:0]      cur_bucket_reg;
    logic [15:0]      cur_segment_reg;
    logic [7:0]       cur_position_reg;
    logic [31:0]      cur_bit_offset_reg;

    // output slot
    logic        m_valid_reg;
    logic [31:0] m_bucket_reg;
    logic [15:0] m_segment_reg;
    logic [7:0]  m_position_reg;
    logic [31:0] m_bit_offset_reg;

    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic             cfg_hit;
    logic [7:0]       grp;
    logic [15:0]      segs;
    logic [IDX_W-1:0] idx;
    logic             accept;
    logic             seq_hit;
    logic [7:0]       pos_inc;
    logic [15:0]      seg_inc;
    logic             pos_wrap;
    logic             seg_wrap;
    logic             out_free;
    logic             out_load;
    logic             div_start;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb begin
        cfg_hit = 1'b1;
        prdata  = '0;
        unique case (cfg_idx)
            REG_OFFSETS_PER_SEG: prdata = PDATA_W'(offs_per_seg_reg);
            REG_SEGS_IN_BUCKET:  prdata = PDATA_W'(segs_in_bucket_reg);
            REG_SEG_WIDTH_BITS:  prdata = PDATA_W'(seg_width_reg);
            default:             cfg_hit = 1'b0;
        endcase
    end

    // zero group sizes behave as one
    assign grp  = (offs_per_seg_reg == 8'd0) ? 8'd1 : offs_per_seg_reg;
    assign segs = (segs_in_bucket_reg == 16'd0) ? 16'd1 : segs_in_bucket_reg;

    // ---------------- sequential-access detect ----------------
    assign idx    = s_entry_index[IDX_W-1:0];
    assign accept = s_valid & s_ready;

    // index zero never steps, even after an all-ones index
    assign seq_hit = last_valid_reg && (idx != '0) && (last_index_reg == idx - 1'b1);

    // nested counter step: position, then segment, then bucket
    assign pos_inc  = cur_position_reg + 8'd1;
    assign seg_inc  = cur_segment_reg + 16'd1;
    assign pos_wrap = (pos_inc == grp);
    assign seg_wrap = (seg_inc == segs);

    assign out_free = ~m_valid_reg | m_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = seq_hit ? ST_FINISH : ST_DIV_SEG;
                end
            end
            ST_DIV_SEG: begin
                if (div_rsp.done) begin
                    state_next = ST_DIV_BKT;
                end
            end
            ST_DIV_BKT: begin
                if (div_rsp.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:    begin
                // no request is taken while reset is held
                s_ready   = aresetn;
                div_start = s_valid & ~seq_hit;
            end
            ST_DIV_SEG: div_start = div_rsp.done;
            ST_DIV_BKT: ;
            ST_MUL:     ;
            ST_FINISH:  out_load = out_free;
            default:    ;
        endcase
    end

    // first divide: index by group size, second: segment number by segments per bucket
    always_comb begin
        div_req.start = div_start;
        if (state_reg == ST_IDLE) begin
            div_req.dividend = DIV_W'(idx);
            div_req.divisor  = DIVISOR_W'(grp);
        end else begin
            div_req.dividend = div_rsp.quot;
            div_req.divisor  = segs;
        end
    end

    sopt_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            last_valid_reg     <= 1'b0;
            m_valid_reg        <= 1'b0;
            offs_per_seg_reg   <= 8'd1;
            segs_in_bucket_reg <= 16'd1;
            seg_width_reg      <= 16'd1;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // any write to a mapped register forces the next request down the divide path
            if (cfg_wr && cfg_hit) begin
                last_valid_reg <= 1'b0;
            end else if (accept) begin
                last_valid_reg <= 1'b1;
            end

            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_OFFSETS_PER_SEG: offs_per_seg_reg   <= pwdata[7:0];
                    REG_SEGS_IN_BUCKET:  segs_in_bucket_reg <= pwdata[15:0];
                    REG_SEG_WIDTH_BITS:  seg_width_reg      <= pwdata[15:0];
                    default:             ;
                endcase
            end
        end
    end

    // ---------------- position registers ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            last_index_reg <= idx;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && seq_hit) begin
                    if (pos_wrap) begin
                        cur_position_reg <= 8'd0;
                        if (seg_wrap) begin
                            cur_segment_reg    <= 16'd0;
                            cur_bucket_reg     <= cur_bucket_reg + 32'd1;
                            cur_bit_offset_reg <= 32'd0;
                        end else begin
                            cur_segment_reg    <= seg_inc;
                            cur_bit_offset_reg <= cur_bit_offset_reg + 32'(seg_width_reg);
                        end
                    end else begin
                        cur_position_reg <= pos_inc;
                    end
                end
            end
            ST_DIV_SEG: begin
                if (div_rsp.done) begin
                    cur_position_reg <= div_rsp.rem[7:0];
                end
            end
            ST_DIV_BKT: begin
                if (div_rsp.done) begin
                    cur_segment_reg <= div_rsp.rem;
                    cur_bucket_reg  <= div_rsp.quot;
                end
            end
            ST_MUL: begin
                cur_bit_offset_reg <= {16'd0, cur_segment_reg} * {16'd0, seg_width_reg};
            end
            ST_FINISH: ;
            default:   ;
        endcase

        if (out_load) begin
            m_bucket_reg     <= cur_bucket_reg;
            m_segment_reg    <= cur_segment_reg;
            m_position_reg   <= cur_position_reg;
            m_bit_offset_reg <= cur_bit_offset_reg;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_bucket_number       = m_bucket_reg;
    assign m_segment_in_bucket   = m_segment_reg;
    assign m_position_in_segment = m_position_reg;
    assign m_segment_bit_offset  = m_bit_offset_reg;

endmodule

// File: design/sopt_divider.sv
module sopt_divider
    import sopt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quot_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] divisor_reg;

    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W+1:0] diff;
    logic                 fits;

    // one restoring step per cycle
    always_comb begin
        rem_shift = {rem_reg, quot_reg[DIV_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, divisor_reg};
        fits      = ~diff[DIVISOR_W+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
            rem_reg  <= fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: design/sopt_checker.sv
module sopt_checker
    import sopt_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [31:0]        m_bucket_number,
    input logic               pready
);

    // one request in flight: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high after accept");

    // a result never shows up in the cycle straight after its accept
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("result too early");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_bucket_number)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind segmented_offset_position_tracker_unit sopt_checker u_sopt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_bucket_number (m_bucket_number),
    .pready          (pready)
);
